// ===== hdl/rlmc_pkg.sv =====
package rlmc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_USE_REGION    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_X      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_Y      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_WIDTH  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_HEIGHT = 3'd7;

  localparam logic [1:0] FMT_GREY = 2'd0;
  localparam logic [1:0] FMT_RGB  = 2'd1;
  localparam logic [1:0] FMT_BGR  = 2'd2;

  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;
  localparam int          LUMA_SHIFT = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [12:0] IMAGE_SIZE_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]         pixel_format;
    logic               use_region;
    logic [12:0]        image_width;
    logic [12:0]        image_height;
    logic signed [16:0] region_x;
    logic signed [16:0] region_y;
    logic [15:0]        region_width;
    logic [15:0]        region_height;
  } cfg_t;

endpackage

// ===== hdl/rlmc_pixel_if.sv =====
interface rlmc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic       frame_end;

  modport source(output valid, output chan_a, output chan_b, output chan_c,
                 output frame_end, input ready);
  modport sink(input valid, input chan_a, input chan_b, input chan_c,
               input frame_end, output ready);
endinterface

// ===== hdl/rlmc_result_if.sv =====
interface rlmc_result_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] mean_q8;
  logic [15:0] rms_q8;

  modport source(output valid, output ok, output mean_q8, output rms_q8, input ready);
  modport sink(input valid, input ok, input mean_q8, input rms_q8, output ready);
endinterface

// ===== hdl/region_luma_mean_rms_contrast_unit.sv =====
// Luma mean and RMS contrast over a frame or a clamped region. Pixels enter
// one per cycle while the result queue has room; a frame_end beat closes the
// frame and its count, sum and sum of squares go into a four-deep queue. The
// back end works through each frame's totals with one shared shift-add
// multiplier, a bit-serial square root and a bit-serial divider, and takes
// the next frame only once the last result is loaded for output; a frame
// with no counted pixel goes straight to the output. Frames shorter than the
// back end's work back up in the queue and then hold off input.
module region_luma_mean_rms_contrast_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  rlmc_pixel_if.sink                       pix,
  rlmc_result_if.source                    res,
  input  logic                             cfg_we,
  input  logic [rlmc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rlmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rlmc_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int QW    = 3 * CNT_W + 24;

  cfg_t              cfg;
  logic              q_push, q_pop, q_empty, q_full, q_space;
  logic [CNT_W-1:0]  tot_count;
  logic [CNT_W+7:0]  tot_sum;
  logic [CNT_W+15:0] tot_sq;
  logic [QW-1:0]     q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format  <= FMT_GREY;
      cfg.use_region    <= 1'b0;
      cfg.image_width   <= IMAGE_SIZE_RESET;
      cfg.image_height  <= IMAGE_SIZE_RESET;
      cfg.region_x      <= '0;
      cfg.region_y      <= '0;
      cfg.region_width  <= '0;
      cfg.region_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT:  cfg.pixel_format  <= cfg_data[1:0];
        REG_USE_REGION:    cfg.use_region    <= cfg_data[0];
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[12:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[12:0];
        REG_REGION_X:      cfg.region_x      <= $signed(cfg_data);
        REG_REGION_Y:      cfg.region_y      <= $signed(cfg_data);
        REG_REGION_WIDTH:  cfg.region_width  <= cfg_data[15:0];
        REG_REGION_HEIGHT: cfg.region_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rlmc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pix      (pix),
    .space_ok (q_space),
    .push     (q_push),
    .tot_count(tot_count),
    .tot_sum  (tot_sum),
    .tot_sq   (tot_sq)
  );

  rlmc_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .din     ({tot_count, tot_sum, tot_sq}),
    .pop     (q_pop),
    .dout    (q_dout),
    .empty   (q_empty),
    .full    (q_full),
    .space_ok(q_space)
  );

  rlmc_back #(
    .CNT_W(CNT_W)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(!q_empty),
    .n_in   (q_dout[QW-1 -: CNT_W]),
    .sum_in (q_dout[2*CNT_W+23 -: CNT_W+8]),
    .sq_in  (q_dout[CNT_W+15:0]),
    .pop    (q_pop),
    .res    (res)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("frame totals pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("frame totals popped from an empty queue");
  a_push_after_beat: assert property (@(posedge clk) disable iff (rst)
    q_push |-> $past(pix.valid && pix.ready))
    else $error("frame totals pushed without a preceding input beat");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ok |-> res.mean_q8 == 16'd0 && res.rms_q8 == 16'd0)
    else $error("empty area result carries nonzero values");

endmodule

// ===== hdl/rlmc_front.sv =====
module rlmc_front #(
  parameter int MAX_WIDTH,
  parameter int MAX_HEIGHT,
  parameter int CNT_W
) (
  input  logic                clk,
  input  logic                rst,
  input  rlmc_pkg::cfg_t      cfg,
  rlmc_pixel_if.sink          pix,
  input  logic                space_ok,
  output logic                push,
  output logic [CNT_W-1:0]    tot_count,
  output logic [CNT_W+7:0]    tot_sum,
  output logic [CNT_W+15:0]   tot_sq
);
  import rlmc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int SUM_W = CNT_W + 8;
  localparam int SQ_W  = CNT_W + 16;

  function automatic logic [18:0] clamp(input logic signed [18:0] v, input logic [18:0] hi);
    logic [18:0] r;
    if (v < 0) r = '0;
    else if (v > $signed(hi)) r = hi;
    else r = v;
    return r;
  endfunction

  logic [COL_W-1:0] w, column, x0, x1;
  logic [ROW_W-1:0] h, row, y0, y1;
  logic [COL_W:0]   column_inc;
  logic signed [18:0] rx, ry, rx_end, ry_end;
  logic counted, accept;
  logic [7:0]  red, blue, luma;
  logic [23:0] wsum;

  logic             s1_valid, s1_counted, s1_end;
  logic [7:0]       s1_luma;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sq;
  logic [15:0]      luma_sq;

  always_comb begin
    if (cfg.image_width == '0) w = COL_W'(1);
    else if (32'(cfg.image_width) > MAX_WIDTH) w = COL_W'(MAX_WIDTH);
    else w = COL_W'(cfg.image_width);
    if (cfg.image_height == '0) h = ROW_W'(1);
    else if (32'(cfg.image_height) > MAX_HEIGHT) h = ROW_W'(MAX_HEIGHT);
    else h = ROW_W'(cfg.image_height);
  end

  assign rx     = cfg.region_x;
  assign ry     = cfg.region_y;
  assign rx_end = rx + $signed({3'b000, cfg.region_width});
  assign ry_end = ry + $signed({3'b000, cfg.region_height});
  assign x0 = COL_W'(clamp(rx, 19'(w)));
  assign x1 = COL_W'(clamp(rx_end, 19'(w)));
  assign y0 = ROW_W'(clamp(ry, 19'(h)));
  assign y1 = ROW_W'(clamp(ry_end, 19'(h)));

  assign counted = column < w && row < h &&
                   (!cfg.use_region ||
                    (column >= x0 && column < x1 && row >= y0 && row < y1));

  // luma weights
  always_comb begin
    red  = pix.chan_a;
    blue = pix.chan_c;
    if (cfg.pixel_format == FMT_BGR) begin
      red  = pix.chan_c;
      blue = pix.chan_a;
    end
    wsum = 24'(W_RED) * 24'(red) + 24'(W_GREEN) * 24'(pix.chan_b) + 24'(W_BLUE) * 24'(blue);
    if (cfg.pixel_format == FMT_RGB || cfg.pixel_format == FMT_BGR) luma = 8'(wsum >> LUMA_SHIFT);
    else luma = pix.chan_a;
  end

  assign pix.ready  = space_ok;
  assign accept     = pix.valid && pix.ready;
  assign column_inc = {1'b0, column} + 1'b1;

  assign luma_sq   = {8'b0, s1_luma} * {8'b0, s1_luma};
  assign tot_count = count + CNT_W'(s1_counted);
  assign tot_sum   = sum + (s1_counted ? SUM_W'(s1_luma) : '0);
  assign tot_sq    = sq + (s1_counted ? SQ_W'(luma_sq) : '0);
  assign push      = s1_valid && s1_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
      count    <= '0;
      sum      <= '0;
      sq       <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (pix.frame_end) begin
          column <= '0;
          row    <= '0;
        end else if (column_inc >= {1'b0, w}) begin
          column <= '0;
          if (row < h) row <= row + 1'b1;
        end else begin
          column <= COL_W'(column_inc);
        end
      end
      if (s1_valid) begin
        if (s1_end) begin
          count <= '0;
          sum   <= '0;
          sq    <= '0;
        end else begin
          count <= tot_count;
          sum   <= tot_sum;
          sq    <= tot_sq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_counted <= counted;
      s1_end     <= pix.frame_end;
      s1_luma    <= luma;
    end
  end

endmodule

// ===== hdl/rlmc_queue.sv =====
module rlmc_queue #(
  parameter int WIDTH,
  parameter int DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full,
  output logic             space_ok
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign empty    = fill == '0;
  assign full     = fill == CNT_W'(DEPTH);
  // room kept for one more beat still inside the front
  assign space_ok = fill < CNT_W'(DEPTH - 1);
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

// ===== hdl/rlmc_back.sv =====
module rlmc_back #(
  parameter int CNT_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [CNT_W-1:0]  n_in,
  input  logic [CNT_W+7:0]  sum_in,
  input  logic [CNT_W+15:0] sq_in,
  output logic              pop,
  rlmc_result_if.source     res
);
  localparam int SUM_W  = CNT_W + 8;
  localparam int SQ_W   = CNT_W + 16;
  localparam int PROD_W = 2 * CNT_W + 16;
  localparam int XW     = PROD_W + 16;
  localparam int RW     = XW / 2;
  localparam int DW     = RW;
  localparam int STEP_W = $clog2(RW);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL_A    = 3'd1;
  localparam logic [2:0] S_MUL_B    = 3'd2;
  localparam logic [2:0] S_DIFF     = 3'd3;
  localparam logic [2:0] S_SQRT     = 3'd4;
  localparam logic [2:0] S_DIV_MEAN = 3'd5;
  localparam logic [2:0] S_DIV_RMS  = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  logic [2:0]        state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  n;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] mc, acc, acc_next, prod1;
  logic [SUM_W-1:0]  mp;
  logic [XW-1:0]     x;
  logic [RW+1:0]     rem;
  logic [RW+3:0]     rem_sh, trial;
  logic [RW-1:0]     root;
  logic [DW-1:0]     dv;
  logic [CNT_W-1:0]  drem;
  logic [CNT_W:0]    r_sh;
  logic              ge;
  logic [15:0]       q, q_next, mean_r, rms_r;
  logic              ok_r;

  assign acc_next = acc + (mp[0] ? mc : '0);
  assign rem_sh   = {rem, x[XW-1 -: 2]};
  assign trial    = (RW + 4)'({root, 2'b01});
  assign r_sh     = {drem, dv[DW-1]};
  assign ge       = r_sh >= {1'b0, n};
  assign q_next   = {q[14:0], ge};
  assign pop      = state == S_IDLE && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!res.valid || res.ready)) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) state <= (n_in == '0) ? S_OUT : S_MUL_A;
        end
        S_MUL_A: begin
          if (step == '0) state <= S_MUL_B;
        end
        S_MUL_B: begin
          if (step == '0) state <= S_DIFF;
        end
        S_DIFF: state <= S_SQRT;
        S_SQRT: begin
          if (step == '0) state <= S_DIV_MEAN;
        end
        S_DIV_MEAN: begin
          if (step == '0) state <= S_DIV_RMS;
        end
        S_DIV_RMS: begin
          if (step == '0) state <= S_OUT;
        end
        S_OUT: begin
          if (!res.valid || res.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        n      <= n_in;
        sum    <= sum_in;
        mc     <= PROD_W'(sq_in);
        mp     <= SUM_W'(n_in);
        acc    <= '0;
        step   <= STEP_W'(CNT_W - 1);
        ok_r   <= n_in != '0;
        mean_r <= '0;
        rms_r  <= '0;
      end
      S_MUL_A: begin
        if (step == '0) begin
          prod1 <= acc_next;
          acc   <= '0;
          mc    <= PROD_W'(sum);
          mp    <= sum;
          step  <= STEP_W'(SUM_W - 1);
        end else begin
          acc  <= acc_next;
          mc   <= mc << 1;
          mp   <= mp >> 1;
          step <= step - 1'b1;
        end
      end
      S_MUL_B: begin
        acc  <= acc_next;
        mc   <= mc << 1;
        mp   <= mp >> 1;
        step <= step - 1'b1;
      end
      S_DIFF: begin
        x    <= {(prod1 >= acc) ? prod1 - acc : {PROD_W{1'b0}}, 16'b0};
        rem  <= '0;
        root <= '0;
        step <= STEP_W'(RW - 1);
      end
      S_SQRT: begin
        x <= x << 2;
        if (rem_sh >= trial) begin
          rem  <= (RW + 2)'(rem_sh - trial);
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= (RW + 2)'(rem_sh);
          root <= {root[RW-2:0], 1'b0};
        end
        if (step == '0) begin
          dv   <= DW'({sum, 8'b0});
          drem <= '0;
          q    <= '0;
          step <= STEP_W'(DW - 1);
        end else begin
          step <= step - 1'b1;
        end
      end
      S_DIV_MEAN, S_DIV_RMS: begin
        if (step == '0) begin
          dv   <= root;
          drem <= '0;
          q    <= '0;
          step <= STEP_W'(DW - 1);
          if (state == S_DIV_MEAN) mean_r <= q_next;
          else rms_r <= q_next;
        end else begin
          dv   <= dv << 1;
          drem <= ge ? CNT_W'(r_sh - {1'b0, n}) : CNT_W'(r_sh);
          q    <= q_next;
          step <= step - 1'b1;
        end
      end
      S_OUT: begin
        if (!res.valid || res.ready) begin
          res.ok      <= ok_r;
          res.mean_q8 <= mean_r;
          res.rms_q8  <= rms_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/rlmc_contrast_checker.sv =====
module rlmc_contrast_checker (
  input  logic        clk,
  input  logic        rst,
  rlmc_pixel_if       pix,
  rlmc_result_if      res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          frames_seen
);
  import rlmc_pkg::*;

  typedef struct {
    logic        ok;
    logic [15:0] mean_q8;
    logic [15:0] rms_q8;
  } stats_t;

  localparam int MAXW = 4096;
  localparam int MAXH = 4096;

  cfg_t         cfg;
  int unsigned  col, row_n;
  longint unsigned cnt, lsum, lsq;
  stats_t       stats_q[$];

  function automatic int unsigned size_of(logic [12:0] v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic longint clamp_to(longint v, longint hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] luma_of(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [31:0] s;
    s = 0;
    if (cfg.pixel_format == FMT_RGB) s = (32'd19595 * a + 32'd38470 * b + 32'd7471 * c) >> 16;
    else if (cfg.pixel_format == FMT_BGR)
      s = (32'd19595 * c + 32'd38470 * b + 32'd7471 * a) >> 16;
    else s = a;
    return s[7:0];
  endfunction

  function automatic bit in_area(int unsigned w, int unsigned h);
    longint x0, x1, y0, y1;
    if (col >= w || row_n >= h) return 0;
    if (!cfg.use_region) return 1;
    if (cfg.region_width == 0 || cfg.region_height == 0) return 0;
    x0 = clamp_to(longint'(cfg.region_x), w);
    x1 = clamp_to(longint'(cfg.region_x) + longint'(cfg.region_width), w);
    y0 = clamp_to(longint'(cfg.region_y), h);
    y1 = clamp_to(longint'(cfg.region_y) + longint'(cfg.region_height), h);
    return longint'(col) >= x0 && longint'(col) < x1 &&
           longint'(row_n) >= y0 && longint'(row_n) < y1;
  endfunction

  function automatic stats_t frame_stats();
    stats_t s;
    logic [127:0] d, s2, d16, cn;
    logic [15:0] r, c;
    s.ok = 0; s.mean_q8 = 0; s.rms_q8 = 0;
    if (cnt == 0) return s;
    d = 128'(cnt) * 128'(lsq);
    s2 = 128'(lsum) * 128'(lsum);
    d = (s2 <= d) ? d - s2 : 0;
    d16 = d << 16;
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      c = r | (16'd1 << i);
      cn = 128'(c) * 128'(cnt);
      if (cn * cn <= d16) r = c;
    end
    s.ok = 1;
    s.mean_q8 = 16'((lsum << 8) / cnt);
    s.rms_q8 = r;
    return s;
  endfunction

  always @(posedge clk) begin
    int unsigned w, h;
    logic [7:0] l;
    stats_t e;
    if (rst) begin
      cfg <= '{pixel_format: 0, use_region: 0, image_width: IMAGE_SIZE_RESET,
               image_height: IMAGE_SIZE_RESET, region_x: 0, region_y: 0,
               region_width: 0, region_height: 0};
      col = 0; row_n = 0; cnt = 0; lsum = 0; lsq = 0;
      stats_q.delete();
      errors <= 0;
      frames_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PIXEL_FORMAT:  cfg.pixel_format  <= cfg_data[1:0];
          REG_USE_REGION:    cfg.use_region    <= cfg_data[0];
          REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[12:0];
          REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[12:0];
          REG_REGION_X:      cfg.region_x      <= cfg_data;
          REG_REGION_Y:      cfg.region_y      <= cfg_data;
          REG_REGION_WIDTH:  cfg.region_width  <= cfg_data[15:0];
          REG_REGION_HEIGHT: cfg.region_height <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        w = size_of(cfg.image_width, MAXW);
        h = size_of(cfg.image_height, MAXH);
        if (in_area(w, h)) begin
          l = luma_of(pix.chan_a, pix.chan_b, pix.chan_c);
          cnt++; lsum += l; lsq += l * l;
        end
        if (pix.frame_end) begin
          stats_q.push_back(frame_stats());
          col = 0; row_n = 0; cnt = 0; lsum = 0; lsq = 0;
        end else begin
          col++;
          if (col >= w) begin
            col = 0;
            if (row_n < h) row_n++;
          end
        end
      end
      if (res.valid && res.ready) begin
        frames_seen <= frames_seen + 1;
        if (stats_q.size() == 0) begin
          $display("%0t: unexpected result ok=%0d mean=%h rms=%h", $time,
                   res.ok, res.mean_q8, res.rms_q8);
          errors <= errors + 1;
        end else begin
          e = stats_q.pop_front();
          if (e.ok !== res.ok || e.mean_q8 !== res.mean_q8 || e.rms_q8 !== res.rms_q8) begin
            $display("%0t: mismatch expected ok=%0d mean=%h rms=%h actual ok=%0d mean=%h rms=%h",
                     $time, e.ok, e.mean_q8, e.rms_q8, res.ok, res.mean_q8, res.rms_q8);
            errors <= errors + 1;
          end
        end
      end
    end
    pending = stats_q.size();
  end
endmodule

// ===== verif/region_luma_mean_rms_contrast_unit_tb.sv =====
module region_luma_mean_rms_contrast_unit_tb;
  import rlmc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = REG_PIXEL_FORMAT;
  logic [16:0] cfg_data = 0;
  int errors, pending, frames_seen;
  int send_idle = 24, recv_idle = 81;
  bit hold_recv = 0;
  int cycles = 0;
  int beats = 0;

  rlmc_pixel_if  pix ();
  rlmc_result_if res ();

  region_luma_mean_rms_contrast_unit u_dut (
    .clk(clk), .rst(rst), .pix(pix.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rlmc_contrast_checker u_check (
    .clk(clk), .rst(rst), .pix(pix), .res(res), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
    .pending(pending), .frames_seen(frames_seen)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    pix.valid = 0; pix.chan_a = 0; pix.chan_b = 0; pix.chan_c = 0; pix.frame_end = 0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout at %0t", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_recv) res.ready <= 0;
    else res.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit last);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      pix.valid <= 0;
      @(posedge clk);
    end
    pix.valid <= 1; pix.chan_a <= a; pix.chan_b <= b; pix.chan_c <= c;
    pix.frame_end <= last;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    beats++;
  endtask

  task automatic send_frame(int n);
    for (int i = 0; i < n; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == n - 1);
  endtask

  task automatic drain();
    pix.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic setup(logic [1:0] fmt, bit reg_on, int w, int h,
                       int rx, int ry, int rw, int rh);
    write_reg(REG_PIXEL_FORMAT, 17'(fmt));
    write_reg(REG_USE_REGION, 17'(reg_on));
    write_reg(REG_IMAGE_WIDTH, 17'(w));
    write_reg(REG_IMAGE_HEIGHT, 17'(h));
    write_reg(REG_REGION_X, 17'(rx));
    write_reg(REG_REGION_Y, 17'(ry));
    write_reg(REG_REGION_WIDTH, 17'(rw));
    write_reg(REG_REGION_HEIGHT, 17'(rh));
    cfg_we <= 0;
  endtask

  function automatic int pick_signed();
    case ($urandom_range(5))
      0: return -65536;
      1: return 65535;
      2: return -$urandom_range(8);
      default: return $urandom_range(12);
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, all formats, empty area, short frames
    send_pixel(8'hff, 8'h00, 8'h00, 0);
    send_pixel(8'h00, 8'hff, 8'hff, 1);
    send_pixel(8'h80, 8'h80, 8'h80, 1);
    drain();
    setup(FMT_RGB, 1'b0, 3, 2, 0, 0, 0, 0);
    send_pixel(8'hff, 8'hff, 8'hff, 0);
    send_pixel(8'h00, 8'h00, 8'h00, 0);
    send_pixel(8'hff, 8'h00, 8'h00, 0);
    send_pixel(8'h00, 8'hff, 8'h00, 0);
    send_pixel(8'h00, 8'h00, 8'hff, 0);
    send_pixel(8'h55, 8'haa, 8'h55, 0);
    send_pixel(8'haa, 8'h55, 8'haa, 0);
    send_pixel(8'h12, 8'h34, 8'h56, 1);
    drain();
    setup(FMT_BGR, 1'b1, 4, 4, -3, 1, 5, 65535);
    send_frame(18);
    drain();
    setup(2'd3, 1'b1, 0, 8191, 0, 0, 0, 7);
    send_frame(4);
    drain();
    setup(FMT_GREY, 1'b1, 8191, 2, 65535, -65536, 65535, 65535);
    send_frame(3);
    drain();

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 81; recv_idle = 24; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      while (beats < 150 + (ph + 1) * 550) begin
        setup(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom_range(7),
              $urandom_range(7), pick_signed(), pick_signed(),
              ($urandom_range(4) == 0) ? 65535 : $urandom_range(9),
              ($urandom_range(4) == 0) ? 65535 : $urandom_range(9));
        if (ph == 2) begin
          fork
            begin
              hold_recv = 1;
              repeat (2000) @(posedge clk);
              hold_recv = 0;
            end
          join_none
        end
        repeat (6) send_frame(($urandom_range(9) == 0) ? 60 : $urandom_range(1, 20));
        drain();
      end
    end
    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d pixel beats over grey/RGB/BGR, whole-frame and clamped regions", beats);
    $display("checked %0d frame results", frames_seen);
    if (errors == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
